@@ design/egcd_pkg.sv @@
package egcd_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef struct packed {
    logic signed [DATA_W-1:0] value_a;
    logic signed [DATA_W-1:0] value_b;
  } egcd_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] divisor_g;
    logic signed [DATA_W-1:0] coef_x;
    logic signed [DATA_W-1:0] coef_y;
  } egcd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } egcd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
  } egcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic b_zero;
  } egcd_status_t;

endpackage

@@ design/extended_gcd_bezout_core.sv @@
// extended euclid core: in_data carries value_a and value_b, out_data returns
// divisor_g with bezout coefficients coef_x and coef_y, a*x + b*y = g
// both channels are valid/stall: an item moves on a rising edge with valid
// high and stall low; the receiving side drives stall
// one item at a time: in_stall stays high from acceptance until the result
// has been taken, so the next item is accepted the cycle after delivery
// the divide step uses truncating division, so g carries the sign that the
// remainder recursion leaves; b equal to zero returns g = a, x = 1, y = 0
// each euclid step (at most about 46 for 32-bit operands) is one pass of a
// bit-serial restoring divider, one quotient bit per cycle, which also
// accumulates |q|*s and |q|*t, followed by an update of the operands and
// coefficients; a check for b equal to zero comes before each step
// reset returns the controller to idle and drops any item in flight
// while out_stall is high the result holds steady on out_data
module extended_gcd_bezout_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  egcd_pkg::egcd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output egcd_pkg::egcd_out_t out_data
);
  import egcd_pkg::*;

  // command and status between controller and datapath
  egcd_cmd_t    cmd;
  egcd_status_t status;

  // sequencer: check, divide, update, repeat until the second operand is zero
  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // operands, serial divider and coefficient registers
  egcd_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

@@ design/egcd_dp.sv @@
module egcd_dp (
  input  logic                    clk,
  input  egcd_pkg::egcd_cmd_t     cmd,
  input  egcd_pkg::egcd_in_t      in_data,
  output egcd_pkg::egcd_status_t  status,
  output egcd_pkg::egcd_out_t     out_data
);
  import egcd_pkg::*;

  // euclid operands
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  // restoring divider on magnitudes
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  // running |q| * s and |q| * t, built msb first alongside the quotient bits
  logic [DATA_W-1:0] prod_s;
  logic [DATA_W-1:0] prod_t;
  // coefficient pairs, mod 2^DATA_W
  logic [DATA_W-1:0] old_s;
  logic [DATA_W-1:0] cur_s;
  logic [DATA_W-1:0] old_t;
  logic [DATA_W-1:0] cur_t;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   dsr_ext;
  logic [DATA_W:0]   diff;
  logic              qbit;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] prod_s_next;
  logic [DATA_W-1:0] prod_t_next;
  logic              q_neg;
  logic [DATA_W-1:0] qs;
  logic [DATA_W-1:0] qt;
  logic [DATA_W-1:0] r_signed;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  always_comb begin
    mag_a = op_a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(op_a)) : DATA_W'(op_a);
    mag_b = op_b[DATA_W-1] ? (DATA_W'(0) - DATA_W'(op_b)) : DATA_W'(op_b);

    shifted  = {rem, dvd[DATA_W-1]};
    dsr_ext  = {1'b0, dsr};
    qbit     = (shifted >= dsr_ext);
    diff     = shifted - dsr_ext;
    rem_next = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];

    prod_s_next = {prod_s[DATA_W-2:0], 1'b0} + (qbit ? cur_s : '0);
    prod_t_next = {prod_t[DATA_W-2:0], 1'b0} + (qbit ? cur_t : '0);

    // truncated quotient sign, remainder follows the dividend
    q_neg    = op_a[DATA_W-1] ^ op_b[DATA_W-1];
    qs       = q_neg ? (DATA_W'(0) - prod_s) : prod_s;
    qt       = q_neg ? (DATA_W'(0) - prod_t) : prod_t;
    r_signed = op_a[DATA_W-1] ? (DATA_W'(0) - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_a  <= in_data.value_a;
      op_b  <= in_data.value_b;
      old_s <= DATA_W'(1);
      cur_s <= '0;
      old_t <= '0;
      cur_t <= DATA_W'(1);
    end else if (cmd.div_init) begin
      rem    <= '0;
      dvd    <= mag_a;
      dsr    <= mag_b;
      prod_s <= '0;
      prod_t <= '0;
    end else if (cmd.div_step) begin
      rem    <= rem_next;
      dvd    <= {dvd[DATA_W-2:0], 1'b0};
      prod_s <= prod_s_next;
      prod_t <= prod_t_next;
    end else if (cmd.update) begin
      op_a  <= op_b;
      op_b  <= $signed(r_signed);
      old_s <= cur_s;
      cur_s <= old_s - qs;
      old_t <= cur_t;
      cur_t <= old_t - qt;
    end
  end

  assign status.b_zero      = (op_b == '0);
  assign out_data.divisor_g = op_a;
  assign out_data.coef_x    = $signed(old_s);
  assign out_data.coef_y    = $signed(old_t);

endmodule

@@ design/egcd_ctrl.sv @@
module egcd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    out_stall,
  input  egcd_pkg::egcd_status_t  status,
  output logic                    in_stall,
  output logic                    out_valid,
  output egcd_pkg::egcd_cmd_t     cmd
);
  import egcd_pkg::*;

  egcd_state_t      state;
  egcd_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_W'(DATA_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= cnt_last ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = status.b_zero ? ST_DONE : ST_DIV;
      ST_DIV:    if (cnt_last) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_DONE:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK:  cmd.div_init = !status.b_zero;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_DONE:   out_valid    = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ tb/tb_extended_gcd_bezout_core.sv @@
module tb_extended_gcd_bezout_core;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  // deepest remainder chain the predictor will follow
  localparam int STEP_LIMIT   = 128;
  // random operand pairs, sent after the directed ones
  localparam int RANDOM_ITEMS = 348;
  // cycles with no item moving on either side before giving up
  // (room for the worst item plus the long result hold, several times over)
  localparam int QUIET_LIMIT  = 20000;
  // long result hold, started once enough items have gone in
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AFTER   = 40;
  // drain tail after the last result
  localparam int TAIL_CYCLES  = 100;

  // consecutive fibonacci numbers: longest remainder chain in 31 bits
  localparam logic [DATA_W-1:0] FIB_HI  = 32'd1836311903;
  localparam logic [DATA_W-1:0] FIB_LO  = 32'd1134903170;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef struct {
    egcd_in_t  ops;
    egcd_out_t res;
  } bezout_expect_t;

  // scoreboard: predicts g, x, y per operand pair and checks results in order
  class bezout_scoreboard;
    bezout_expect_t expected_results[$];
    int errors;
    int checked;

    // truncating remainder recursion down, coefficient back-substitution up
    static function egcd_out_t solve_bezout(egcd_in_t op);
      longint      num, den, rem_v;
      longint      quo [STEP_LIMIT];
      logic [63:0] cx, cy, tmp;
      int          depth;
      egcd_out_t   res;
      num   = longint'($signed(op.value_a));
      den   = longint'($signed(op.value_b));
      depth = 0;
      while (den != 0 && depth < STEP_LIMIT) begin
        rem_v      = num % den;
        quo[depth] = num / den;
        depth++;
        num = den;
        den = rem_v;
      end
      cx = 64'd1;
      cy = 64'd0;
      for (int i = depth - 1; i >= 0; i--) begin
        tmp = cx;
        cx  = cy;
        cy  = tmp - 64'(quo[i]) * cy;
      end
      res.divisor_g = num[DATA_W-1:0];
      res.coef_x    = cx[DATA_W-1:0];
      res.coef_y    = cy[DATA_W-1:0];
      return res;
    endfunction

    function void note_operands(egcd_in_t op);
      bezout_expect_t e;
      e.ops = op;
      e.res = solve_bezout(op);
      expected_results.push_back(e);
    endfunction

    function void check_result(egcd_out_t got);
      bezout_expect_t e;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: g=%0d x=%0d y=%0d",
               got.divisor_g, got.coef_x, got.coef_y);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (got.divisor_g !== e.res.divisor_g) begin
        $error("divisor_g (a=%0d b=%0d): expected %0d, got %0d",
               e.ops.value_a, e.ops.value_b, e.res.divisor_g, got.divisor_g);
        errors++;
      end
      if (got.coef_x !== e.res.coef_x) begin
        $error("coef_x (a=%0d b=%0d): expected %0d, got %0d",
               e.ops.value_a, e.ops.value_b, e.res.coef_x, got.coef_x);
        errors++;
      end
      if (got.coef_y !== e.res.coef_y) begin
        $error("coef_y (a=%0d b=%0d): expected %0d, got %0d",
               e.ops.value_a, e.ops.value_b, e.res.coef_y, got.coef_y);
        errors++;
      end
    endfunction

    function void flag_leftovers();
      foreach (expected_results[i]) begin
        $error("no result for a=%0d b=%0d", expected_results[i].ops.value_a,
               expected_results[i].ops.value_b);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  egcd_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  egcd_out_t out_data;

  bezout_scoreboard sb;
  int n_sent;      // items the sender has seen accepted
  int n_accepted;  // items seen by the input monitor
  int n_results;   // results seen by the output monitor
  int quiet_cycles;

  extended_gcd_bezout_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitors sample pre-edge values; all drivers use nonblocking updates
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_operands(in_data);
      n_accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_data);
      n_results++;
    end
  end

  // watchdog: any stretch with nothing moving on either side ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stall bursts, mostly short, with open stretches
  // and one long hold while the sender keeps offering
  initial begin
    int unsigned pick;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_accepted >= HOLD_AFTER) begin
        // block fills with one finished result and must stall its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(0, 40)) @(posedge clk);
        end else if (pick < 93) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(0, 4)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 200)) @(posedge clk);
        end
      end
    end
  end

  // offer one operand pair and hold it until accepted; valid stays high
  // on return so back-to-back items need no second update in one step
  task automatic offer_operands(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    in_valid        <= 1'b1;
    in_data.value_a <= a;
    in_data.value_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // random idle between items, mostly none or short, now and then long
  task automatic sender_gap();
    int unsigned pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      n = 0;
    else if (pick < 90)
      n = $urandom_range(1, 6);
    else
      n = $urandom_range(20, 120);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // operand drawn from a mix of full-width, small, medium, zero and extreme values
  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned sel;
    logic [DATA_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      v = $urandom;
    else if (sel < 60)
      v = $urandom_range(1, 1000);
    else if (sel < 80)
      v = $urandom_range(1, 1 << 20);
    else if (sel < 86)
      v = '0;
    else begin
      case ($urandom_range(0, 4))
        0:       v = POS_MAX;
        1:       v = NEG_MIN;
        2:       v = NEG_MIN + 1;
        3:       v = 1;
        default: v = POS_MAX - 1;
      endcase
    end
    if ($urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  initial begin
    logic [DATA_W-1:0] a, b, k, f0, f1, tmp;
    int unsigned sel;
    int steps;
    sb = new();
    n_sent       = 0;
    n_accepted   = 0;
    n_results    = 0;
    quiet_cycles = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero operands, extremes, signs, deepest chains
    offer_operands(0, 0);
    offer_operands(5, 0);             // zero second operand
    offer_operands(-7, 0);
    offer_operands(0, 5);
    offer_operands(0, -7);
    offer_operands(12, 18);
    offer_operands(-12, 18);
    offer_operands(12, -18);
    offer_operands(-240, -46);
    offer_operands(1, 1);
    offer_operands(-1, -1);
    offer_operands(POS_MAX, POS_MAX);
    offer_operands(POS_MAX, -POS_MAX);
    offer_operands(POS_MAX, POS_MAX - 1);
    offer_operands(FIB_HI, FIB_LO);   // longest remainder chain
    offer_operands(-FIB_HI, FIB_LO);
    offer_operands(FIB_LO, -FIB_HI);
    offer_operands(NEG_MIN, 0);       // most negative value, outside nominal range
    offer_operands(NEG_MIN, 1);
    offer_operands(NEG_MIN, -1);
    offer_operands(NEG_MIN, NEG_MIN);
    offer_operands(1, NEG_MIN);
    offer_operands(NEG_MIN, FIB_HI);
    offer_operands(-POS_MAX, 3);

    // random operand pairs with varied structure
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        a = pick_operand();
        b = pick_operand();
      end else if (sel < 80) begin
        // shared factor so g is not trivially one
        k = $urandom_range(2, 5000);
        a = k * $urandom_range(1, 400000);
        b = k * $urandom_range(1, 400000);
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
      end else begin
        // neighboring fibonacci numbers give long chains
        steps = $urandom_range(5, 44);
        f0 = 0;
        f1 = 1;
        repeat (steps) begin
          tmp = f0 + f1;
          f0  = f1;
          f1  = tmp;
        end
        a = f1;
        b = f0;
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
      end
      offer_operands(a, b);
      if (i == RANDOM_ITEMS / 2) begin
        // sender pause until the block has drained completely
        in_valid <= 1'b0;
        while (n_results != n_sent) @(posedge clk);
      end else begin
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    while (n_results != n_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftovers();

    $display("run covered %0d operand pairs (zero, extreme, shared-factor and fibonacci)",
             n_sent);
    $display("%0d results compared, %0d field mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
design/egcd_pkg.sv
design/egcd_dp.sv
design/egcd_ctrl.sv
design/extended_gcd_bezout_core.sv
tb/tb_extended_gcd_bezout_core.sv
